// ===== sv/sha1_stream_hash_assert.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA1_STREAM_HASH_ASSERT_SVH
`define SHA1_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHA1S_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA1S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sha1s_pkg.sv =====
package sha1s_pkg;

  // Five chaining / working words, index 0 is word A (H0).
  typedef logic [4:0][31:0] hash_t;

  localparam hash_t HashInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  localparam int unsigned RndW = 7;
  localparam logic [RndW-1:0] RndGroup1 = 7'd20;
  localparam logic [RndW-1:0] RndGroup2 = 7'd40;
  localparam logic [RndW-1:0] RndGroup3 = 7'd60;
  localparam logic [RndW-1:0] RndLast   = 7'd79;

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [7:0] PadZero = 8'h00;
  localparam logic [5:0] PosLen  = 6'd56;
  localparam logic [5:0] PosLast = 6'd63;

  localparam logic CmdAppend = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } rctl_t;

endpackage

// ===== sv/sha1s_sched.sv =====
// Byte packing and 16-word message schedule window.
module sha1s_sched (
  input  logic        clk,
  input  logic        push,
  input  logic [7:0]  push_byte,
  input  logic        word_end,
  input  logic        step,
  output logic [31:0] w_t
);
  import sha1s_pkg::*;

  logic [23:0]       acc_r, acc_nxt;
  logic [15:0][31:0] win_r, win_nxt;
  logic [31:0]       mix;

  // W[t+16] from the window holding W[t..t+15]
  assign mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];

  always_comb begin
    acc_nxt = acc_r;
    win_nxt = win_r;
    if (push) begin
      acc_nxt = {acc_r[15:0], push_byte};
      if (word_end) begin
        win_nxt = {{acc_r, push_byte}, win_r[15:1]};
      end
    end else if (step) begin
      win_nxt = {{mix[30:0], mix[31]}, win_r[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    win_r <= win_nxt;
  end

  assign w_t = win_r[0];

endmodule

// ===== sv/sha1s_round.sv =====
// One SHA-1 round per cycle while ctl.step is high, over registered working words A..E.
module sha1s_round (
  input  logic              clk,
  input  sha1s_pkg::rctl_t  ctl,
  input  sha1s_pkg::hash_t  chain,
  input  logic [31:0]       w_t,
  output sha1s_pkg::hash_t  work
);
  import sha1s_pkg::*;

  hash_t       work_r, work_nxt;
  logic [31:0] a, b, c, d, e;
  logic [31:0] f_val, k_val, sum;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    if (ctl.rnd < RndGroup1) begin
      f_val = (b & c) | (~b & d);
      k_val = RoundK0;
    end else if (ctl.rnd < RndGroup2) begin
      f_val = b ^ c ^ d;
      k_val = RoundK1;
    end else if (ctl.rnd < RndGroup3) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = RoundK2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = RoundK3;
    end
  end

  assign sum = {a[26:0], a[31:27]} + f_val + e + k_val + w_t;

  always_comb begin
    work_nxt = work_r;
    if (ctl.load) begin
      work_nxt = chain;
    end else if (ctl.step) begin
      work_nxt = {d, c, {b[1:0], b[31:2]}, a, sum};
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work = work_r;

endmodule

// ===== sv/sha1_stream_hash.sv =====
// SHA-1 stream hasher. Each input item is either an append (one message byte) or a
// finish. The append that completes a 64-byte block starts a busy phase (80 rounds
// through the single round unit, then the fold into the chaining words), during
// which in_stall is high. A finish feeds the padding bytes (0x80, zeros, 64-bit
// big-endian bit count) one per cycle through the same byte path, pausing for the
// busy phase of each block so completed (one or two), then presents the five digest
// words H0..H4 on the result channel, one item per word, with out_last_word on H4.
// Once H4 is taken the hasher is back at the initial chaining values with a zero
// bit count, ready for the next message. The append rate is bounded by the serial
// byte intake and the one-round-per-cycle compression unit, which hold off appends
// for the busy phase of each block.
`include "sha1_stream_hash_assert.svh"

module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_last_word
);
  import sha1s_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic [2:0] EmitLast = 3'd4;
  localparam logic [2:0] LenLast  = 3'd7;

  state_t          state_r, state_nxt;
  logic [5:0]      pos_r, pos_nxt;          // fill position in the block
  logic [63:0]     bit_cnt_r, bit_cnt_nxt;  // message length in bits, wraps
  hash_t           chain_r, chain_nxt;
  logic            fin_r, fin_nxt;          // finishing a message
  logic            mark_r, mark_nxt;        // 0x80 still to go
  logic            len_act_r, len_act_nxt;  // sending the length field
  logic [2:0]      len_idx_r, len_idx_nxt;
  logic            pad_done_r, pad_done_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [2:0]      emit_cnt_r, emit_cnt_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        fin_acc;
  logic        fresh_msg;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [31:0] w_t;
  rctl_t       rctl;
  hash_t       work;

  assign in_acc  = in_valid && (state_r == ST_IDLE);
  assign out_acc = out_valid && !out_stall;

  // length bytes go out most significant first
  assign len_byte = bit_cnt_r[{~len_idx_r, 3'b000} +: 8];

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    bit_cnt_nxt  = bit_cnt_r;
    chain_nxt    = chain_r;
    fin_nxt      = fin_r;
    mark_nxt     = mark_r;
    len_act_nxt  = len_act_r;
    len_idx_nxt  = len_idx_r;
    pad_done_nxt = pad_done_r;
    rnd_nxt      = rnd_r;
    emit_cnt_nxt = emit_cnt_r;
    push         = 1'b0;
    push_byte    = in_data_byte;
    rctl.load    = 1'b0;
    rctl.step    = 1'b0;
    rctl.rnd     = rnd_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CmdAppend) begin
            push        = 1'b1;
            bit_cnt_nxt = bit_cnt_r + 64'd8;
          end else begin
            fin_nxt      = 1'b1;
            mark_nxt     = 1'b1;
            len_act_nxt  = 1'b0;
            len_idx_nxt  = '0;
            pad_done_nxt = 1'b0;
            state_nxt    = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (mark_r) begin
          push_byte = PadMark;
          mark_nxt  = 1'b0;
        end else if (len_act_r || (pos_r == PosLen)) begin
          push_byte   = len_byte;
          len_act_nxt = 1'b1;
          len_idx_nxt = len_idx_r + 3'd1;
          if (len_idx_r == LenLast) begin
            pad_done_nxt = 1'b1;
          end
        end else begin
          push_byte = PadZero;
        end
      end
      ST_ROUND: begin
        rctl.step = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == RndLast) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 5; i++) begin
          chain_nxt[i] = chain_r[i] + work[i];
        end
        emit_cnt_nxt = '0;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (pad_done_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          // rotate so the next word sits at index 0
          chain_nxt    = {chain_r[0], chain_r[4:1]};
          emit_cnt_nxt = emit_cnt_r + 3'd1;
          if (emit_cnt_r == EmitLast) begin
            chain_nxt   = HashInit;
            bit_cnt_nxt = '0;
            pos_nxt     = '0;
            fin_nxt     = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // byte into the block; a full block starts the compression
    if (push) begin
      pos_nxt = pos_r + 6'd1;
      if (pos_r == PosLast) begin
        rctl.load = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      bit_cnt_r  <= '0;
      chain_r    <= HashInit;
      fin_r      <= 1'b0;
      mark_r     <= 1'b0;
      len_act_r  <= 1'b0;
      len_idx_r  <= '0;
      pad_done_r <= 1'b0;
      rnd_r      <= '0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      chain_r    <= chain_nxt;
      fin_r      <= fin_nxt;
      mark_r     <= mark_nxt;
      len_act_r  <= len_act_nxt;
      len_idx_r  <= len_idx_nxt;
      pad_done_r <= pad_done_nxt;
      rnd_r      <= rnd_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  sha1s_sched u_sched (
    .clk       (clk),
    .push      (push),
    .push_byte (push_byte),
    .word_end  (pos_r[1:0] == 2'b11),
    .step      (rctl.step),
    .w_t       (w_t)
  );

  sha1s_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain_r),
    .w_t   (w_t),
    .work  (work)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = chain_r[0];
  assign out_last_word   = (emit_cnt_r == EmitLast);

  assign fin_acc   = in_acc && (in_command == CmdFinish);
  assign fresh_msg = (bit_cnt_r == '0) && (pos_r == '0) && (chain_r == HashInit);

  // no new item while the digest is going out
  `SHA1S_ASSERT_IMPL(a_no_in_during_out, clk, rst_n, out_valid, in_stall, "input open in digest")
  // a finish always leads straight into padding
  `SHA1S_ASSERT_NEXT(a_finish_busy, clk, rst_n, fin_acc, state_r == ST_PAD, "idle after finish")
  // last digest word taken: state back to a fresh message
  `SHA1S_ASSERT_NEXT(a_restart, clk, rst_n, out_acc && out_last_word, fresh_msg, "no restart")
  // compression only ever runs on a whole block
  `SHA1S_ASSERT_IMPL(a_fold_full_block, clk, rst_n, state_r == ST_FOLD, pos_r == '0, "bad fold")
  // round counter stays within the 80 rounds
  `SHA1S_ASSERT_IMPL(a_round_range, clk, rst_n, state_r == ST_ROUND, rnd_r <= RndLast, "bad round")

endmodule
